@@ hdl/boxds_pkg.sv @@
// Shared types and constants for the box-average image downscaler.
// Depends on nothing; the top, the line memory and the testbench import it.
package boxds_pkg;

	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 13;
	localparam int unsigned DimW = 13;
	localparam int unsigned StartW = 14;
	localparam int unsigned SumW = 32;
	localparam int unsigned BlkW = 26;

	localparam logic [CfgIdxW-1:0] CFG_IN_WIDTH = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_IN_HEIGHT = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_OUT_WIDTH = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_OUT_HEIGHT = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_CHANNELS = 3'd4;

	localparam logic [2:0] FOUR_CHANNELS = 3'd4;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [7:0] alpha_in;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic [7:0] alpha_out;
		logic       frame_end;
	} pixel_out_t;

	typedef struct packed {
		logic [SumW-1:0] red;
		logic [SumW-1:0] green;
		logic [SumW-1:0] blue;
		logic [SumW-1:0] alpha;
	} sums_t;

endpackage

@@ hdl/box_average_image_downscaler.sv @@
// Box-average image downscaler: raster pixels in, block averages out.
// Pixels are taken only in the idle state, one at a time: the next pixel waits for the
// read-modify-write of the line memory, and a pixel that closes a block also waits for
// the sum dividers and a free result register. A size write first reruns the setup
// dividers. Reset clears counters and block positions and loads the default sizes;
// the line memory is not cleared, since every block overwrites its entry.
module box_average_image_downscaler #(
	parameter int unsigned MAX_WIDTH = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [boxds_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [boxds_pkg::CfgDataW-1:0]    cfg_data,
	input  logic                              pix_valid,
	output logic                              pix_ready,
	input  boxds_pkg::pixel_in_t              pix,
	output logic                              res_valid,
	input  logic                              res_ready,
	output boxds_pkg::pixel_out_t             res
);
	import boxds_pkg::*;

	localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_CFG  = 5'b00010,
		S_ACC  = 5'b00100,
		S_DIV  = 5'b01000,
		S_WAIT = 5'b10000
	} state_t;

	state_t state_q;

	logic [DimW-1:0] in_w_q, in_h_q;
	logic [11:0] out_w_q, out_h_q;
	logic [2:0] chan_q;
	logic dirty_q;

	logic [DimW-1:0] bw_q, bh_q, wrem_q, hrem_q;
	logic [DimW-1:0] in_col_q, in_row_q, out_col_q, out_row_q;
	logic [StartW-1:0] bcs_q, brs_q;
	logic [DimW-1:0] crem_q, rrem_q;

	pixel_in_t pix_q;
	logic fe_q;
	pixel_out_t res_q;
	logic res_valid_q;

	logic four;
	assign four = (chan_q == FOUR_CHANNELS);

	// Setup dividers for block sizes and start steps.
	logic cfg_start, cdiv_busy_w, cdiv_busy_h, cdiv_done, cdiv_done_h;
	logic [DimW-1:0] wq, wr, hq, hr;
	assign cfg_start = (state_q == S_IDLE) && dirty_q;

	boxds_div #(.N(DimW)) u_div_w (
		.clk(clk), .arst_n(arst_n), .start(cfg_start),
		.dividend(in_w_q), .divisor({1'b0, out_w_q}),
		.busy(cdiv_busy_w), .done(cdiv_done), .quotient(wq), .remainder(wr)
	);
	boxds_div #(.N(DimW)) u_div_h (
		.clk(clk), .arst_n(arst_n), .start(cfg_start),
		.dividend(in_h_q), .divisor({1'b0, out_h_q}),
		.busy(cdiv_busy_h), .done(cdiv_done_h), .quotient(hq), .remainder(hr)
	);

	// Line memory.
	logic [14:0] oc_ext;
	logic [AW-1:0] mem_addr;
	logic mem_we;
	sums_t mem_rd, mem_wd;
	assign oc_ext = 15'(out_col_q);
	assign mem_addr = oc_ext[AW-1:0];

	boxds_line_mem #(.DEPTH(MAX_WIDTH)) u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_addr), .wdata(mem_wd),
		.raddr(mem_addr), .rdata(mem_rd)
	);

	// Block membership of the current pixel.
	logic [14:0] dr, dc;
	logic in_rows, in_cols, last_col, row_last, emit, first;
	logic [13:0] c_next, r_next;
	assign dr = {2'b00, in_row_q} - {1'b0, brs_q};
	assign dc = {2'b00, in_col_q} - {1'b0, bcs_q};
	assign in_rows = (bh_q != '0) && ({1'b0, out_row_q} < {2'b00, out_h_q})
		&& ({1'b0, in_row_q} >= brs_q) && (dr < {2'b00, bh_q});
	assign in_cols = (bw_q != '0) && ({1'b0, out_col_q} < {2'b00, out_w_q})
		&& (32'(out_col_q) < MAX_WIDTH)
		&& ({1'b0, in_col_q} >= bcs_q) && (dc < {2'b00, bw_q});
	assign last_col = in_cols && (dc == {2'b00, bw_q - DimW'(1)});
	assign row_last = dr == {2'b00, bh_q - DimW'(1)};
	assign emit = in_rows && last_col && row_last;
	assign first = ({1'b0, in_row_q} == brs_q) && ({1'b0, in_col_q} == bcs_q);
	assign c_next = {1'b0, in_col_q} + 14'd1;
	assign r_next = {1'b0, in_row_q} + 14'd1;
	assign mem_we = (state_q == S_ACC) && in_rows && in_cols;

	always_comb begin
		if (first) begin
			mem_wd.red = SumW'(pix_q.red_in);
			mem_wd.green = SumW'(pix_q.green_in);
			mem_wd.blue = SumW'(pix_q.blue_in);
			mem_wd.alpha = SumW'(pix_q.alpha_in);
		end else begin
			mem_wd.red = mem_rd.red + SumW'(pix_q.red_in);
			mem_wd.green = mem_rd.green + SumW'(pix_q.green_in);
			mem_wd.blue = mem_rd.blue + SumW'(pix_q.blue_in);
			mem_wd.alpha = mem_rd.alpha + SumW'(pix_q.alpha_in);
		end
	end

	// Sum dividers.
	logic [2*DimW-1:0] blk_prod;
	logic [SumW-1:0] blk;
	logic sdiv_start, sdiv_done, sdiv_busy;
	logic [3:0] sb, sd;
	logic [SumW-1:0] qr, qg, qb, qa;
	logic [SumW-1:0] unused_r [4];
	assign blk_prod = bw_q * bh_q;
	assign blk = (blk_prod == '0) ? SumW'(1) : SumW'(blk_prod[BlkW-1:0]);
	assign sdiv_start = (state_q == S_ACC) && emit;
	assign sdiv_done = sd[0];
	assign sdiv_busy = |sb;

	boxds_div #(.N(SumW)) u_div_r (.clk(clk), .arst_n(arst_n), .start(sdiv_start),
		.dividend(mem_wd.red), .divisor(blk), .busy(sb[0]), .done(sd[0]),
		.quotient(qr), .remainder(unused_r[0]));
	boxds_div #(.N(SumW)) u_div_g (.clk(clk), .arst_n(arst_n), .start(sdiv_start),
		.dividend(mem_wd.green), .divisor(blk), .busy(sb[1]), .done(sd[1]),
		.quotient(qg), .remainder(unused_r[1]));
	boxds_div #(.N(SumW)) u_div_b (.clk(clk), .arst_n(arst_n), .start(sdiv_start),
		.dividend(mem_wd.blue), .divisor(blk), .busy(sb[2]), .done(sd[2]),
		.quotient(qb), .remainder(unused_r[2]));
	boxds_div #(.N(SumW)) u_div_a (.clk(clk), .arst_n(arst_n), .start(sdiv_start),
		.dividend(mem_wd.alpha), .divisor(blk), .busy(sb[3]), .done(sd[3]),
		.quotient(qa), .remainder(unused_r[3]));

	assign pix_ready = (state_q == S_IDLE) && !dirty_q;

	// Block start advance for columns and rows.
	logic [StartW-1:0] bcs_adv, brs_adv;
	logic [DimW-1:0] crem_adv, rrem_adv;
	logic [DimW:0] csum, rsum;
	assign csum = {1'b0, crem_q} + {1'b0, wrem_q};
	assign rsum = {1'b0, rrem_q} + {1'b0, hrem_q};
	always_comb begin
		bcs_adv = bcs_q + {1'b0, bw_q};
		crem_adv = csum[DimW-1:0];
		if (csum >= {2'b00, out_w_q}) begin
			crem_adv = DimW'(csum - {2'b00, out_w_q});
			bcs_adv = bcs_adv + StartW'(1);
		end
		brs_adv = brs_q + {1'b0, bh_q};
		rrem_adv = rsum[DimW-1:0];
		if (rsum >= {2'b00, out_h_q}) begin
			rrem_adv = DimW'(rsum - {2'b00, out_h_q});
			brs_adv = brs_adv + StartW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			in_w_q <= 13'd640;
			in_h_q <= 13'd480;
			out_w_q <= 12'd320;
			out_h_q <= 12'd240;
			chan_q <= 3'd4;
			dirty_q <= 1'b1;
			in_col_q <= '0;
			in_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			bcs_q <= '0;
			brs_q <= '0;
			crem_q <= '0;
			rrem_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_IN_WIDTH: in_w_q <= cfg_data;
					CFG_IN_HEIGHT: in_h_q <= cfg_data;
					CFG_OUT_WIDTH: out_w_q <= cfg_data[11:0];
					CFG_OUT_HEIGHT: out_h_q <= cfg_data[11:0];
					CFG_CHANNELS: chan_q <= cfg_data[2:0];
					default: ;
				endcase
				if (cfg_index inside {CFG_IN_WIDTH, CFG_IN_HEIGHT, CFG_OUT_WIDTH,
						CFG_OUT_HEIGHT}) begin
					dirty_q <= 1'b1;
				end
			end
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (dirty_q) begin
						state_q <= S_CFG;
						if (!(cfg_we && cfg_index inside {CFG_IN_WIDTH, CFG_IN_HEIGHT,
								CFG_OUT_WIDTH, CFG_OUT_HEIGHT})) begin
							dirty_q <= 1'b0;
						end
					end else if (pix_valid) begin
						state_q <= S_ACC;
					end
				end
				S_CFG: begin
					if (cdiv_done) begin
						state_q <= S_IDLE;
					end
				end
				S_ACC: begin
					state_q <= emit ? S_DIV : S_IDLE;
					if (last_col) begin
						out_col_q <= out_col_q + DimW'(1);
						bcs_q <= bcs_adv;
						crem_q <= crem_adv;
					end
					if (c_next >= {1'b0, in_w_q}) begin
						in_col_q <= '0;
						out_col_q <= '0;
						bcs_q <= '0;
						crem_q <= '0;
						if (in_rows && row_last) begin
							out_row_q <= out_row_q + DimW'(1);
							brs_q <= brs_adv;
							rrem_q <= rrem_adv;
						end
						if (r_next >= {1'b0, in_h_q}) begin
							in_row_q <= '0;
							out_row_q <= '0;
							brs_q <= '0;
							rrem_q <= '0;
						end else begin
							in_row_q <= r_next[DimW-1:0];
						end
					end else begin
						in_col_q <= c_next[DimW-1:0];
					end
				end
				S_DIV: begin
					if (sdiv_done) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (!res_valid_q || res_ready) begin
						res_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pix_valid && pix_ready) begin
			pix_q.red_in <= pix.red_in;
			pix_q.green_in <= pix.green_in;
			pix_q.blue_in <= pix.blue_in;
			pix_q.alpha_in <= four ? pix.alpha_in : 8'd0;
		end
		if (cdiv_done) begin
			bw_q <= (out_w_q == '0) ? '0 : wq;
			wrem_q <= (out_w_q == '0) ? '0 : wr;
		end
		if (cdiv_done_h) begin
			bh_q <= (out_h_q == '0) ? '0 : hq;
			hrem_q <= (out_h_q == '0) ? '0 : hr;
		end
		if (sdiv_start) begin
			fe_q <= ({1'b0, out_col_q} + 14'd1 == {2'b00, out_w_q})
				&& ({1'b0, out_row_q} + 14'd1 == {2'b00, out_h_q});
		end
		if ((state_q == S_WAIT) && (!res_valid_q || res_ready)) begin
			res_q.red_out <= qr[7:0];
			res_q.green_out <= qg[7:0];
			res_q.blue_out <= qb[7:0];
			res_q.alpha_out <= four ? qa[7:0] : 8'd0;
			res_q.frame_end <= fe_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	a_acc_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ACC |-> $past(pix_valid && pix_ready))
		else $error("line update without a pixel transfer");
	a_res_from_wait: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q == S_WAIT))
		else $error("result raised outside the wait state");
	a_div_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!((cdiv_busy_w || cdiv_busy_h) && sdiv_busy))
		else $error("setup and sum dividers busy together");
endmodule

@@ hdl/boxds_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing beyond its parameter.
module boxds_div #(
	parameter int unsigned N = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [N-1:0] dividend,
	input  logic [N-1:0] divisor,
	output logic         busy,
	output logic         done,
	output logic [N-1:0] quotient,
	output logic [N-1:0] remainder
);
	localparam int unsigned CW = $clog2(N + 1);

	logic [N-1:0] rem_q, quo_q, den_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;
	logic [N:0] shifted;
	logic [N:0] diff;

	assign shifted = {rem_q, quo_q[N-1]};
	assign diff = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(N);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			if (shifted >= {1'b0, den_q}) begin
				rem_q <= diff[N-1:0];
				quo_q <= {quo_q[N-2:0], 1'b1};
			end else begin
				rem_q <= shifted[N-1:0];
				quo_q <= {quo_q[N-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;
endmodule

@@ hdl/boxds_line_mem.sv @@
// Line memory of per-column channel sums, one write and one registered read port.
// Depends on boxds_pkg for the sum record type.
module boxds_line_mem #(
	parameter int unsigned DEPTH = 4096
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [$clog2(DEPTH)-1:0]     waddr,
	input  boxds_pkg::sums_t             wdata,
	input  logic [$clog2(DEPTH)-1:0]     raddr,
	output boxds_pkg::sums_t             rdata
);
	import boxds_pkg::*;

	sums_t mem [DEPTH];
	sums_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

@@ test/testbench.sv @@
// Self-checking bench for box_average_image_downscaler: whole frames of random and
// patterned pixels under many size settings, each result checked against a built-in model.
// Depends on boxds_pkg and the RTL top only.
`timescale 1ns / 1ps

module testbench;
	import boxds_pkg::*;

	localparam int unsigned LineDepth = 4096;
	localparam int unsigned StallLimit = 5000;
	localparam int unsigned ItemTarget = 850;

	localparam int unsigned FillRandom = 0;
	localparam int unsigned FillOnes = 1;
	localparam int unsigned FillZeros = 2;
	localparam int unsigned FillAlternate = 3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = CFG_IN_WIDTH;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic pix_valid = 1'b0;
	logic pix_ready;
	pixel_in_t pix = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	pixel_out_t res;

	box_average_image_downscaler u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pix_valid(pix_valid), .pix_ready(pix_ready), .pix(pix),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	always #1 clk = ~clk;

	pixel_in_t pixel_q[$];
	pixel_out_t avg_q[$];
	int unsigned fail_count = 0;
	int unsigned pixels_sent = 0;
	int unsigned averages_seen = 0;
	int unsigned frames_sent = 0;
	int unsigned stall_cycles = 0;
	bit idle_on = 1'b1;

	// Model copy of the registers and the downscaler state.
	logic [12:0] m_in_w, m_in_h;
	logic [11:0] m_out_w, m_out_h;
	logic [2:0] m_chan;
	logic [31:0] sum_r[LineDepth], sum_g[LineDepth], sum_b[LineDepth], sum_a[LineDepth];
	int unsigned col, row, ocol, orow, col_start, col_rem, row_start, row_rem;

	task automatic step_start(inout int unsigned start, inout int unsigned rem,
			input int unsigned isz, input int unsigned osz);
		start += (osz != 0) ? isz / osz : 0;
		rem += (osz != 0) ? isz % osz : 0;
		if (rem >= osz) begin
			rem -= osz;
			start += 1;
		end
	endtask

	task automatic predict_pixel(input pixel_in_t p);
		int unsigned bw, bh, blk, x;
		bit four, in_rows, in_cols, last_col;
		pixel_out_t avg;
		bw = (m_out_w != 0) ? m_in_w / m_out_w : 0;
		bh = (m_out_h != 0) ? m_in_h / m_out_h : 0;
		four = (m_chan == FOUR_CHANNELS);
		in_rows = bh != 0 && orow < m_out_h && row >= row_start && row - row_start < bh;
		in_cols = bw != 0 && ocol < m_out_w && ocol < LineDepth &&
			col >= col_start && col - col_start < bw;
		last_col = in_cols && (col - col_start == bw - 1);
		if (in_rows && in_cols) begin
			x = ocol;
			if (row == row_start && col == col_start) begin
				sum_r[x] = 32'(p.red_in);
				sum_g[x] = 32'(p.green_in);
				sum_b[x] = 32'(p.blue_in);
				sum_a[x] = four ? 32'(p.alpha_in) : 32'd0;
			end else begin
				sum_r[x] += 32'(p.red_in);
				sum_g[x] += 32'(p.green_in);
				sum_b[x] += 32'(p.blue_in);
				sum_a[x] += four ? 32'(p.alpha_in) : 32'd0;
			end
			if (last_col && row - row_start == bh - 1) begin
				blk = bw * bh;
				avg.red_out = 8'(sum_r[x] / blk);
				avg.green_out = 8'(sum_g[x] / blk);
				avg.blue_out = 8'(sum_b[x] / blk);
				avg.alpha_out = four ? 8'(sum_a[x] / blk) : 8'd0;
				avg.frame_end = (x + 1 == m_out_w) && (orow + 1 == m_out_h);
				avg_q.push_back(avg);
			end
		end
		if (last_col) begin
			ocol += 1;
			step_start(col_start, col_rem, m_in_w, m_out_w);
		end
		if (col + 1 >= m_in_w) begin
			col = 0;
			ocol = 0;
			col_start = 0;
			col_rem = 0;
			if (in_rows && row - row_start == bh - 1) begin
				orow += 1;
				step_start(row_start, row_rem, m_in_h, m_out_h);
			end
			if (row + 1 >= m_in_h) begin
				row = 0;
				orow = 0;
				row_start = 0;
				row_rem = 0;
			end else begin
				row += 1;
			end
		end else begin
			col += 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
		end else begin
			if (pix_valid && pix_ready) begin
				predict_pixel(pix);
				pixels_sent++;
			end
			if (!pix_valid || pix_ready) begin
				if (pixel_q.size() != 0 && !(idle_on && $urandom_range(99) < 25)) begin
					pix <= pixel_q.pop_front();
					pix_valid <= 1'b1;
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				averages_seen++;
				if (avg_q.size() == 0) begin
					$display("%0t: unexpected result %p", $time, res);
					fail_count++;
				end else begin
					if (res !== avg_q[0]) begin
						$display("%0t: mismatch expected %p actual %p", $time, avg_q[0], res);
						fail_count++;
					end
					void'(avg_q.pop_front());
				end
			end
			res_ready <= !(idle_on && $urandom_range(99) < 25);
		end
	end

	always @(posedge clk) begin
		if ((pix_valid && pix_ready) || (res_valid && res_ready) || cfg_we)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= StallLimit) begin
			$display("%0t: no transfer for %0d cycles", $time, StallLimit);
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CfgDataW'(val);
		case (idx)
			CFG_IN_WIDTH: m_in_w = 13'(val);
			CFG_IN_HEIGHT: m_in_h = 13'(val);
			CFG_OUT_WIDTH: m_out_w = 12'(val);
			CFG_OUT_HEIGHT: m_out_h = 12'(val);
			CFG_CHANNELS: m_chan = 3'(val);
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (pixel_q.size() != 0 || pix_valid || avg_q.size() != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_sizes(input int unsigned iw, ih, ow, oh, ch);
		wait_drained();
		write_reg(CFG_IN_WIDTH, iw);
		write_reg(CFG_IN_HEIGHT, ih);
		write_reg(CFG_OUT_WIDTH, ow);
		write_reg(CFG_OUT_HEIGHT, oh);
		write_reg(CFG_CHANNELS, ch);
		@(posedge clk);
		cfg_we <= 1'b0;
		repeat (20) @(posedge clk);
	endtask

	// Fill patterns: random, all ones, all zeros, or alternating extremes.
	task automatic queue_frame(input int unsigned mode);
		pixel_in_t p;
		int unsigned n;
		for (n = 0; n < m_in_w * m_in_h; n++) begin
			case (mode)
				FillOnes: p = '1;
				FillZeros: p = '0;
				FillAlternate: p = n[0] ? '1 : '0;
				default: p = $urandom;
			endcase
			pixel_q.push_back(p);
		end
		frames_sent++;
	endtask

	initial begin
		int unsigned iw, ih, ch;
		m_in_w = 640;
		m_in_h = 480;
		m_out_w = 320;
		m_out_h = 240;
		m_chan = FOUR_CHANNELS;
		col = 0; row = 0; ocol = 0; orow = 0;
		col_start = 0; col_rem = 0; row_start = 0; row_rem = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		set_sizes(2, 2, 1, 1, 4);
		queue_frame(FillOnes);
		queue_frame(FillZeros);
		set_sizes(3, 3, 2, 2, 3);
		queue_frame(FillOnes);
		set_sizes(5, 2, 2, 1, 4);
		queue_frame(FillAlternate);
		// Long stretch without any idling on either side.
		idle_on = 1'b0;
		set_sizes(40, 6, 13, 2, 4);
		queue_frame(FillRandom);
		wait_drained();
		idle_on = 1'b1;
		set_sizes(2, 60, 1, 59, 3);
		queue_frame(FillRandom);
		set_sizes(30, 4, 1, 1, 4);
		queue_frame(FillOnes);
		while (pixels_sent + pixel_q.size() < ItemTarget) begin
			iw = $urandom_range(12, 2);
			ih = $urandom_range(10, 2);
			ch = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(4, 3);
			set_sizes(iw, ih, $urandom_range(iw - 1, 1), $urandom_range(ih - 1, 1), ch);
			repeat ($urandom_range(3, 1)) queue_frame(FillRandom);
		end
		wait_drained();
		$display("Sent %0d pixels in %0d frames; %0d block averages checked.",
			pixels_sent, frames_sent, averages_seen);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ box_average_image_downscaler.f @@
hdl/boxds_pkg.sv
hdl/boxds_div.sv
hdl/boxds_line_mem.sv
hdl/box_average_image_downscaler.sv
test/testbench.sv
